### sv/kwm_pkg.sv
// Shared constants, types and helper functions of the k-way ordered merge.
package kwm_pkg;

   // Sizing
   localparam int CHANNELS    = 8;
   localparam int FIFO_DEPTH  = 8;
   localparam int MAX_RESULTS = 64;
   localparam int QUEUE_DEPTH = 2;

   // Field widths
   localparam int CHANNEL_W = 3;
   localparam int ORDINAL_W = 64;
   localparam int PAYLOAD_W = 32;
   localparam int LENGTH_W  = 16;
   localparam int CFG_W     = 4;
   localparam int CFG_RESET = 8;

   // Derived widths
   localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int PTR_W    = $clog2(FIFO_DEPTH);
   localparam int FILL_W   = $clog2(FIFO_DEPTH + 1);
   localparam int CNT_W    = $clog2(CHANNELS + 1);
   localparam int ADDR_W   = $clog2(CHANNELS * FIFO_DEPTH);
   localparam int RES_W    = (MAX_RESULTS > 1) ? $clog2(MAX_RESULTS) : 1;
   localparam int QPTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W   = $clog2(QUEUE_DEPTH + 1);

   typedef logic [CH_IDX_W-1:0] ch_idx_type;
   typedef logic [PTR_W-1:0]    ptr_type;
   typedef logic [FILL_W-1:0]   fill_type;
   typedef logic [CNT_W-1:0]    cnt_type;
   typedef logic [ADDR_W-1:0]   addr_type;
   typedef logic [RES_W-1:0]    res_cnt_type;
   typedef logic [QPTR_W-1:0]   qptr_type;
   typedef logic [QCNT_W-1:0]   qcnt_type;
   typedef logic [CFG_W-1:0]    cfg_type;

   // One stored record
   typedef struct packed {
      logic [ORDINAL_W-1:0] ordinal;
      logic [PAYLOAD_W-1:0] payload;
      logic [LENGTH_W-1:0]  length;
   } record_type;

   // Classified input beat, front to back
   typedef struct packed {
      logic                 known;
      logic [CHANNEL_W-1:0] channel;
      record_type           rec;
   } item_type;

   // Result beat
   typedef struct packed {
      logic       record_valid;
      record_type rec;
      logic       accepted;
      logic       overflow;
      logic       last;
   } result_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_STORE,
      ST_CHECK,
      ST_SCAN,
      ST_EMIT
   } kwm_state_type;

   // Circular FIFO pointer advance
   function automatic ptr_type next_ptr(input ptr_type p);
      ptr_type r;
      if (int'(p) >= FIFO_DEPTH - 1) begin
         r = '0;
      end else begin
         r = p + ptr_type'(1);
      end
      return r;
   endfunction

   // Flat store address of a channel's slot
   function automatic addr_type store_addr(input ch_idx_type ch, input ptr_type p);
      int a;
      a = int'(ch) * FIFO_DEPTH + int'(p);
      return addr_type'(a);
   endfunction

   // Effective channel count: zero acts as one, too large acts as CHANNELS
   function automatic cnt_type eff_count(input cfg_type cfg);
      cnt_type r;
      if (cfg == '0) begin
         r = cnt_type'(1);
      end else if (int'(cfg) > CHANNELS) begin
         r = cnt_type'(CHANNELS);
      end else begin
         r = cnt_type'(cfg);
      end
      return r;
   endfunction

endpackage

### sv/kwm_if.sv
// Request and response channel interfaces of the k-way ordered merge.
interface kwm_req_if;
   logic                          valid;
   logic                          ready;
   logic [kwm_pkg::CHANNEL_W-1:0] channel;
   logic [kwm_pkg::ORDINAL_W-1:0] ordinal;
   logic [kwm_pkg::PAYLOAD_W-1:0] payload;
   logic [kwm_pkg::LENGTH_W-1:0]  length;

   modport source (output valid, output channel, output ordinal, output payload,
                   output length, input ready);
   modport sink (input valid, input channel, input ordinal, input payload,
                 input length, output ready);
endinterface

interface kwm_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          record_valid;
   logic [kwm_pkg::ORDINAL_W-1:0] out_ordinal;
   logic [kwm_pkg::PAYLOAD_W-1:0] out_payload;
   logic [kwm_pkg::LENGTH_W-1:0]  out_length;
   logic                          accepted;
   logic                          overflow;
   logic                          last;

   modport source (output valid, output record_valid, output out_ordinal,
                   output out_payload, output out_length, output accepted,
                   output overflow, output last, input ready);
   modport sink (input valid, input record_valid, input out_ordinal,
                 input out_payload, input out_length, input accepted,
                 input overflow, input last, output ready);
endinterface

### sv/k_way_ordered_merge.sv
// Top level of the k-way ordered merge: channel register, front end and back end.
//
// Records arriving on req_bus are appended to the FIFO of their channel; whenever
// every channel in use holds a record, the one with the smallest ordinal (lower
// channel on ties) is released on rsp_bus. Each request beat yields one or more
// response beats, the final one flagged by last; a beat with record_valid 0 reports
// a step that released nothing. The head search before each released record reads
// the FIFO heads of the channels in use one per cycle from the single read port of
// the record store. A two-beat queue lets new requests be taken while the back end
// works. csr_wdata sets channels_in_use (0 acts as 1, above 8 acts as 8); write it
// only while the block is idle.
module k_way_ordered_merge (
   input  logic                   clock,
   input  logic                   reset,
   kwm_req_if.sink                req_bus,
   kwm_rsp_if.source              rsp_bus,
   input  logic                   csr_we,
   input  kwm_pkg::cfg_type       csr_wdata
);

   kwm_pkg::cfg_type    channels_in_use_ff, channels_in_use_in;
   kwm_pkg::cnt_type    n_eff;
   logic                q_valid;
   kwm_pkg::item_type   q_item;
   logic                q_pop;
   logic                out_valid;
   kwm_pkg::result_type out_result;

   // Channel count register
   assign channels_in_use_in = csr_we ? csr_wdata : channels_in_use_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         channels_in_use_ff <= kwm_pkg::cfg_type'(kwm_pkg::CFG_RESET);
      end else begin
         channels_in_use_ff <= channels_in_use_in;
      end
   end

   assign n_eff = kwm_pkg::eff_count(channels_in_use_ff);

   kwm_front u_front (
      .clock   (clock),
      .reset   (reset),
      .n_eff   (n_eff),
      .req_bus (req_bus),
      .q_valid (q_valid),
      .q_item  (q_item),
      .q_pop   (q_pop)
   );

   kwm_back u_back (
      .clock      (clock),
      .reset      (reset),
      .n_eff      (n_eff),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop),
      .rsp_ready  (rsp_bus.ready),
      .out_valid  (out_valid),
      .out_result (out_result)
   );

   // Response channel
   assign rsp_bus.valid        = out_valid;
   assign rsp_bus.record_valid = out_result.record_valid;
   assign rsp_bus.out_ordinal  = out_result.rec.ordinal;
   assign rsp_bus.out_payload  = out_result.rec.payload;
   assign rsp_bus.out_length   = out_result.rec.length;
   assign rsp_bus.accepted     = out_result.accepted;
   assign rsp_bus.overflow     = out_result.overflow;
   assign rsp_bus.last         = out_result.last;

endmodule

### sv/kwm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module kwm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/kwm_front.sv
// Front end: accepts request beats, marks unknown channels, queues them for the back end.
module kwm_front (
   input  logic                clock,
   input  logic                reset,
   input  kwm_pkg::cnt_type    n_eff,
   kwm_req_if.sink             req_bus,
   output logic                q_valid,
   output kwm_pkg::item_type   q_item,
   input  logic                q_pop
);

   kwm_pkg::item_type q_ff [kwm_pkg::QUEUE_DEPTH];
   kwm_pkg::item_type q_in;
   kwm_pkg::qptr_type wr_ptr_ff, wr_ptr_in;
   kwm_pkg::qptr_type rd_ptr_ff, rd_ptr_in;
   kwm_pkg::qcnt_type count_ff, count_in;
   logic              push;
   logic              pop;

   // Classify the incoming beat
   always_comb begin
      q_in.known   = int'(req_bus.channel) < int'(n_eff);
      q_in.channel = req_bus.channel;
      q_in.rec.ordinal = req_bus.ordinal;
      q_in.rec.payload = req_bus.payload;
      q_in.rec.length  = req_bus.length;
   end

   assign req_bus.ready = int'(count_ff) < kwm_pkg::QUEUE_DEPTH;
   assign push          = req_bus.valid && req_bus.ready;
   assign pop           = q_pop && (count_ff != '0);
   assign q_valid       = count_ff != '0;
   assign q_item        = q_ff[rd_ptr_ff];

   // Pointer and count updates
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (int'(wr_ptr_ff) == kwm_pkg::QUEUE_DEPTH - 1) ? '0
                     : wr_ptr_ff + kwm_pkg::qptr_type'(1);
      end
      if (pop) begin
         rd_ptr_in = (int'(rd_ptr_ff) == kwm_pkg::QUEUE_DEPTH - 1) ? '0
                     : rd_ptr_ff + kwm_pkg::qptr_type'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + kwm_pkg::qcnt_type'(1);
      end else if (pop && !push) begin
         count_in = count_ff - kwm_pkg::qcnt_type'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= q_in;
      end
   end

endmodule

### sv/kwm_back.sv
// Back end: stores records in per-channel FIFOs and releases the smallest head ordinal.
module kwm_back (
   input  logic                 clock,
   input  logic                 reset,
   input  kwm_pkg::cnt_type     n_eff,
   input  logic                 q_valid,
   input  kwm_pkg::item_type    q_item,
   output logic                 q_pop,
   input  logic                 rsp_ready,
   output logic                 out_valid,
   output kwm_pkg::result_type  out_result
);

   kwm_pkg::kwm_state_type state_ff, state_in;

   kwm_pkg::item_type    item_ff, item_in;
   logic                 acc_ff, acc_in;
   logic                 ovf_ff, ovf_in;
   kwm_pkg::fill_type    fill_ff [kwm_pkg::CHANNELS];
   kwm_pkg::fill_type    fill_in [kwm_pkg::CHANNELS];
   kwm_pkg::ptr_type     head_ff [kwm_pkg::CHANNELS];
   kwm_pkg::ptr_type     head_in [kwm_pkg::CHANNELS];
   kwm_pkg::ptr_type     tail_ff [kwm_pkg::CHANNELS];
   kwm_pkg::ptr_type     tail_in [kwm_pkg::CHANNELS];
   kwm_pkg::cnt_type     scan_idx_ff, scan_idx_in;
   logic                 rd_pending_ff, rd_pending_in;
   kwm_pkg::ch_idx_type  rd_ch_ff, rd_ch_in;
   kwm_pkg::record_type  best_ff, best_in;
   kwm_pkg::ch_idx_type  best_ch_ff, best_ch_in;
   kwm_pkg::res_cnt_type res_cnt_ff, res_cnt_in;
   logic                 out_valid_ff, out_valid_in;
   kwm_pkg::result_type  out_ff, out_in;

   kwm_pkg::ch_idx_type  item_ch;
   kwm_pkg::ch_idx_type  scan_ch;
   logic                 item_full;
   logic                 do_store;
   logic                 all_nonempty;
   logic                 slot_free;
   logic                 last_rel;
   logic                 scan_done;
   logic                 ram_wr;
   logic                 ram_rd;
   logic                 out_load;
   logic                 emit_record;
   kwm_pkg::addr_type    wr_addr;
   kwm_pkg::addr_type    rd_addr;
   kwm_pkg::record_type  rd_data;

   // Record store, all channels
   kwm_ram #(
      .WIDTH ($bits(kwm_pkg::record_type)),
      .DEPTH (kwm_pkg::CHANNELS * kwm_pkg::FIFO_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr),
      .wr_addr (wr_addr),
      .wr_data (item_ff.rec),
      .rd_en   (ram_rd),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Status terms
   always_comb begin
      item_ch   = kwm_pkg::ch_idx_type'(item_ff.channel);
      scan_ch   = scan_idx_ff[kwm_pkg::CH_IDX_W-1:0];
      item_full = fill_ff[item_ch] == kwm_pkg::fill_type'(kwm_pkg::FIFO_DEPTH);
      do_store  = item_ff.known && !item_full;
      wr_addr   = kwm_pkg::store_addr(item_ch, tail_ff[item_ch]);
      rd_addr   = kwm_pkg::store_addr(scan_ch, head_ff[scan_ch]);
      slot_free = !out_valid_ff || rsp_ready;
      scan_done = scan_idx_ff == n_eff;
      all_nonempty = 1'b1;
      for (int c = 0; c < kwm_pkg::CHANNELS; c++) begin
         if ((c < int'(n_eff)) && (fill_ff[c] == '0)) begin
            all_nonempty = 1'b0;
         end
      end
      // final release once a channel in use runs dry or the result cap is hit
      last_rel = !(all_nonempty && (fill_ff[best_ch_ff] != kwm_pkg::fill_type'(1)))
                 || (res_cnt_ff == kwm_pkg::res_cnt_type'(kwm_pkg::MAX_RESULTS - 1));
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         kwm_pkg::ST_IDLE: begin
            if (q_valid) begin
               state_in = kwm_pkg::ST_STORE;
            end
         end
         kwm_pkg::ST_STORE: begin
            state_in = kwm_pkg::ST_CHECK;
         end
         kwm_pkg::ST_CHECK: begin
            if (all_nonempty) begin
               state_in = kwm_pkg::ST_SCAN;
            end else if (slot_free) begin
               state_in = kwm_pkg::ST_IDLE;
            end
         end
         kwm_pkg::ST_SCAN: begin
            if (scan_done) begin
               state_in = kwm_pkg::ST_EMIT;
            end
         end
         kwm_pkg::ST_EMIT: begin
            if (slot_free) begin
               state_in = last_rel ? kwm_pkg::ST_IDLE : kwm_pkg::ST_SCAN;
            end
         end
         default: begin
            state_in = kwm_pkg::ST_IDLE;
         end
      endcase
   end

   // State outputs
   always_comb begin
      q_pop       = 1'b0;
      ram_wr      = 1'b0;
      ram_rd      = 1'b0;
      out_load    = 1'b0;
      emit_record = 1'b0;
      case (state_ff)
         kwm_pkg::ST_IDLE: begin
            q_pop = q_valid;
         end
         kwm_pkg::ST_STORE: begin
            ram_wr = do_store;
         end
         kwm_pkg::ST_CHECK: begin
            out_load = !all_nonempty && slot_free;
         end
         kwm_pkg::ST_SCAN: begin
            ram_rd = int'(scan_idx_ff) < int'(n_eff);
         end
         kwm_pkg::ST_EMIT: begin
            out_load    = slot_free;
            emit_record = slot_free;
         end
         default: begin
            q_pop = 1'b0;
         end
      endcase
   end

   // Datapath next values
   always_comb begin
      item_in       = item_ff;
      acc_in        = acc_ff;
      ovf_in        = ovf_ff;
      fill_in       = fill_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      scan_idx_in   = scan_idx_ff;
      rd_pending_in = ram_rd;
      rd_ch_in      = scan_ch;
      best_in       = best_ff;
      best_ch_in    = best_ch_ff;
      res_cnt_in    = res_cnt_ff;
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;

      if (q_pop) begin
         item_in = q_item;
      end

      // classify against the FIFO fill and append
      if (state_ff == kwm_pkg::ST_STORE) begin
         acc_in     = do_store;
         ovf_in     = item_ff.known && item_full;
         res_cnt_in = '0;
         if (do_store) begin
            tail_in[item_ch] = kwm_pkg::next_ptr(tail_ff[item_ch]);
            fill_in[item_ch] = fill_ff[item_ch] + kwm_pkg::fill_type'(1);
         end
      end

      // scan counter: restart before each search
      if ((state_ff == kwm_pkg::ST_CHECK) || (state_ff == kwm_pkg::ST_EMIT)) begin
         scan_idx_in = '0;
      end else if (state_ff == kwm_pkg::ST_SCAN) begin
         scan_idx_in = scan_idx_ff + kwm_pkg::cnt_type'(1);
      end

      // running minimum; strict less keeps the lower channel on ties
      if (rd_pending_ff) begin
         if ((rd_ch_ff == '0) || (rd_data.ordinal < best_ff.ordinal)) begin
            best_in    = rd_data;
            best_ch_in = rd_ch_ff;
         end
      end

      // release the winner
      if (emit_record) begin
         head_in[best_ch_ff] = kwm_pkg::next_ptr(head_ff[best_ch_ff]);
         fill_in[best_ch_ff] = fill_ff[best_ch_ff] - kwm_pkg::fill_type'(1);
         res_cnt_in          = res_cnt_ff + kwm_pkg::res_cnt_type'(1);
      end

      // output register
      if (out_load) begin
         out_valid_in    = 1'b1;
         out_in.accepted = acc_ff;
         out_in.overflow = ovf_ff;
         if (emit_record) begin
            out_in.record_valid = 1'b1;
            out_in.rec          = best_ff;
            out_in.last         = last_rel;
         end else begin
            out_in.record_valid = 1'b0;
            out_in.rec          = '0;
            out_in.last         = 1'b1;
         end
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= kwm_pkg::ST_IDLE;
         fill_ff       <= '{default: '0};
         head_ff       <= '{default: '0};
         tail_ff       <= '{default: '0};
         scan_idx_ff   <= '0;
         rd_pending_ff <= 1'b0;
         res_cnt_ff    <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         fill_ff       <= fill_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         scan_idx_ff   <= scan_idx_in;
         rd_pending_ff <= rd_pending_in;
         res_cnt_ff    <= res_cnt_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      item_ff    <= item_in;
      acc_ff     <= acc_in;
      ovf_ff     <= ovf_in;
      rd_ch_ff   <= rd_ch_in;
      best_ff    <= best_in;
      best_ch_ff <= best_ch_in;
      out_ff     <= out_in;
   end

   assign out_valid  = out_valid_ff;
   assign out_result = out_ff;

`ifndef ASSERT_OFF
   // a released record always comes from a channel that holds one
   a_release_nonempty: assert property (@(posedge clock) disable iff (reset)
      emit_record |-> (fill_ff[best_ch_ff] != '0))
      else $error("release from empty channel");

   // accepted and overflow are exclusive on every beat
   a_acc_ovf: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> !(out_ff.accepted && out_ff.overflow))
      else $error("accepted and overflow both set");

   // an empty result is always the final one of its step
   a_empty_last: assert property (@(posedge clock) disable iff (reset)
      (out_load && !emit_record) |=> out_ff.last)
      else $error("empty result without last");

   // after the final result the sequencer is ready for the next beat
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (out_load && (!emit_record || last_rel)) |=> (state_ff == kwm_pkg::ST_IDLE))
      else $error("sequencer not idle after final result");
`endif

endmodule
